FILE: rtl/core/hlmdu_pkg.sv
// ----------------------------------------------------------------------------
// hlmdu_pkg
// Shared types and constants for the hi/lo multiply/divide unit.
// ----------------------------------------------------------------------------
package hlmdu_pkg;

   // operand width and iteration count of the shared step unit
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned STEP_COUNT = 32;
   localparam int unsigned COUNT_W    = 5;

   // command codes; codes 6 and 7 leave the pipe registers alone
   typedef enum logic [2:0] {
      CMD_MULT  = 3'd0,
      CMD_MULTU = 3'd1,
      CMD_DIV   = 3'd2,
      CMD_DIVU  = 3'd3,
      CMD_MADD  = 3'd4,
      CMD_MADDU = 3'd5
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_FIX,
      ST_ACC,
      ST_FIN
   } state_type;

   // step unit operation
   typedef enum logic {
      MODE_MUL,
      MODE_DIV
   } step_mode_type;

   // input item
   typedef struct packed {
      logic [2:0]  command;
      logic        pipe_select;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
      logic [4:0]  dest_reg;
   } req_item_type;

   // result item
   typedef struct packed {
      logic signed [31:0] lo_out;
      logic signed [31:0] hi_out;
      logic               dest_write;
      logic [4:0]         dest_index;
   } rsp_item_type;

endpackage

FILE: rtl/core/hi_lo_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// hi_lo_multiply_divide_unit
// Multiply, multiply-add and divide into two HI/LO register pipes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_item (command, pipe, rs, rt, dest)
//  rsp      out        rsp_valid/rsp_stall  rsp_item (lo, hi, dest write, dest index)
//
//  an item runs through the shared add/subtract step unit, one product or
//  quotient bit a cycle, then a sign fix step for multiply forms, a hi:lo
//  add step for multiply-adds, then a finish step that registers the result;
//  unused command codes go straight to the finish step. no new item is taken
//  until the sequencer is back in idle after the finish step.
//  reset clears both HI/LO pipes and the sequencer.
//  a result waiting on rsp_stall holds the next item in its finish cycle.
// ----------------------------------------------------------------------------
module hi_lo_multiply_divide_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hlmdu_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hlmdu_pkg::rsp_item_type rsp_item
);
   import hlmdu_pkg::*;

   localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(STEP_COUNT - 1);

   // control registers
   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          lo_ff [0:1];
   logic [31:0]          lo_in [0:1];
   logic [31:0]          hi_ff [0:1];
   logic [31:0]          hi_in [0:1];

   // payload registers
   cmd_type              cmd_ff, cmd_in;
   logic                 pipe_ff, pipe_in;
   logic [4:0]           dest_ff, dest_in;
   logic [31:0]          b_ff, b_in;
   logic [31:0]          part_hi_ff, part_hi_in;
   logic [31:0]          part_lo_ff, part_lo_in;
   logic                 neg_q_ff, neg_q_in;
   logic                 neg_r_ff, neg_r_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   // datapath signals
   step_mode_type        mode;
   logic [31:0]          step_hi;
   logic [31:0]          step_lo;
   logic [63:0]          wide_a;
   logic [63:0]          wide_b;
   logic [63:0]          wide_sum;
   logic                 accept;
   logic                 is_signed;
   logic                 is_mul;
   logic                 is_div;
   logic [31:0]          rs_mag;
   logic [31:0]          rt_mag;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // shared iteration unit
   assign mode = (cmd_ff == CMD_DIV || cmd_ff == CMD_DIVU) ? MODE_DIV : MODE_MUL;

   hlmdu_step_unit u_step (
      .mode      (mode),
      .part_hi   (part_hi_ff),
      .part_lo   (part_lo_ff),
      .operand_b (b_ff),
      .next_hi   (step_hi),
      .next_lo   (step_lo)
   );

   // 64-bit adder for product negate and hi:lo accumulate
   always_comb begin
      if (state_ff == ST_FIX) begin
         wide_a = ~{part_hi_ff, part_lo_ff};
         wide_b = 64'd1;
      end else begin
         wide_a = {part_hi_ff, part_lo_ff};
         wide_b = {hi_ff[pipe_ff], lo_ff[pipe_ff]};
      end
      wide_sum = wide_a + wide_b;
   end

   // operand decode at accept
   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      is_signed = 1'b0;
      unique case (req_item.command)
         CMD_MULT, CMD_MADD: begin
            is_mul    = 1'b1;
            is_signed = 1'b1;
         end
         CMD_MULTU, CMD_MADDU: begin
            is_mul = 1'b1;
         end
         CMD_DIV: begin
            is_div    = 1'b1;
            is_signed = 1'b1;
         end
         CMD_DIVU: begin
            is_div = 1'b1;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
      rs_mag = (is_signed && req_item.rs_value[31]) ? (32'd0 - req_item.rs_value)
                                                    : req_item.rs_value;
      rt_mag = (is_signed && req_item.rt_value[31]) ? (32'd0 - req_item.rt_value)
                                                    : req_item.rt_value;
   end

   // sequencer next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cmd_in       = cmd_ff;
      pipe_in      = pipe_ff;
      dest_in      = dest_ff;
      b_in         = b_ff;
      part_hi_in   = part_hi_ff;
      part_lo_in   = part_lo_ff;
      neg_q_in     = neg_q_ff;
      neg_r_in     = neg_r_ff;
      rsp_item_in  = rsp_item_ff;

      // result taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = cmd_type'(req_item.command);
               pipe_in    = req_item.pipe_select;
               dest_in    = req_item.dest_reg;
               b_in       = rt_mag;
               part_hi_in = 32'd0;
               part_lo_in = rs_mag;
               neg_q_in   = is_signed && (req_item.rs_value[31] ^ req_item.rt_value[31]);
               neg_r_in   = is_signed && req_item.rs_value[31];
               count_in   = '0;
               state_in   = (is_mul || is_div) ? ST_RUN : ST_FIN;
            end
         end
         ST_RUN: begin
            part_hi_in = step_hi;
            part_lo_in = step_lo;
            count_in   = count_ff + COUNT_W'(1);
            if (count_ff == LAST_STEP) begin
               state_in = (mode == MODE_DIV) ? ST_FIN : ST_FIX;
            end
         end
         ST_FIX: begin
            if (neg_q_ff) begin
               part_hi_in = wide_sum[63:32];
               part_lo_in = wide_sum[31:0];
            end
            state_in = (cmd_ff == CMD_MADD || cmd_ff == CMD_MADDU) ? ST_ACC : ST_FIN;
         end
         ST_ACC: begin
            part_hi_in = wide_sum[63:32];
            part_lo_in = wide_sum[31:0];
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_item_in.dest_index = dest_ff;
               rsp_item_in.dest_write = 1'b0;
               unique case (cmd_ff)
                  CMD_MULT, CMD_MULTU, CMD_MADD, CMD_MADDU: begin
                     lo_in[pipe_ff] = part_lo_ff;
                     hi_in[pipe_ff] = part_hi_ff;
                     rsp_item_in.dest_write = (dest_ff != 5'd0);
                  end
                  CMD_DIV, CMD_DIVU: begin
                     lo_in[pipe_ff] = neg_q_ff ? (32'd0 - part_lo_ff) : part_lo_ff;
                     hi_in[pipe_ff] = neg_r_ff ? (32'd0 - part_hi_ff) : part_hi_ff;
                  end
                  default: begin
                     lo_in[pipe_ff] = lo_ff[pipe_ff];
                  end
               endcase
               rsp_item_in.lo_out = lo_in[pipe_ff];
               rsp_item_in.hi_out = hi_in[pipe_ff];
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= CMD_MULT;
         lo_ff[0]     <= 32'd0;
         lo_ff[1]     <= 32'd0;
         hi_ff[0]     <= 32'd0;
         hi_ff[1]     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pipe_ff     <= pipe_in;
      dest_ff     <= dest_in;
      b_ff        <= b_in;
      part_hi_ff  <= part_hi_in;
      part_lo_ff  <= part_lo_in;
      neg_q_ff    <= neg_q_in;
      neg_r_ff    <= neg_r_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule

FILE: rtl/core/hlmdu_step_unit.sv
// ----------------------------------------------------------------------------
// hlmdu_step_unit
// One iteration of shift-add multiply or restoring divide on a shared adder.
// ----------------------------------------------------------------------------
module hlmdu_step_unit (
   input  hlmdu_pkg::step_mode_type mode,
   input  logic [31:0]              part_hi,
   input  logic [31:0]              part_lo,
   input  logic [31:0]              operand_b,
   output logic [31:0]              next_hi,
   output logic [31:0]              next_lo
);
   import hlmdu_pkg::*;

   logic [33:0] add_a;
   logic [33:0] add_b;
   logic [33:0] add_sum;
   logic        do_sub;

   // operand select for the shared adder
   always_comb begin
      unique case (mode)
         MODE_MUL: begin
            add_a  = {2'b00, part_hi};
            add_b  = part_lo[0] ? {2'b00, operand_b} : 34'd0;
            do_sub = 1'b0;
         end
         MODE_DIV: begin
            add_a  = {1'b0, part_hi, part_lo[31]};
            add_b  = {2'b00, operand_b};
            do_sub = 1'b1;
         end
      endcase
      add_sum = add_a + (do_sub ? ~add_b : add_b) + {33'd0, do_sub};
   end

   // next partial values
   always_comb begin
      unique case (mode)
         MODE_MUL: begin
            next_hi = add_sum[32:1];
            next_lo = {add_sum[0], part_lo[31:1]};
         end
         MODE_DIV: begin
            if (add_sum[33]) begin
               next_hi = {part_hi[30:0], part_lo[31]};
               next_lo = {part_lo[30:0], 1'b0};
            end else begin
               next_hi = add_sum[31:0];
               next_lo = {part_lo[30:0], 1'b1};
            end
         end
      endcase
   end

endmodule
